// ===== hdl/bsbp_pkg.sv =====
// shared types and constants for the bitmap set-bit position block
package bsbp_pkg;

	localparam int WORD_BITS       = 64;
	localparam int IDX_BITS        = 6;
	localparam int WIDX_BITS       = 26;
	localparam int FULL_POS_BITS   = 32;
	localparam int SLOT_FIELD_BITS = 20;
	localparam int CFG_DATA_BITS   = 32;
	localparam int CFG_INDEX_BITS  = 2;
	localparam int S_TDATA_BITS    = 96;
	localparam int M_TDATA_BITS    = 56;

	localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_START = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_END   = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_SLOT    = 2'd2;

	typedef struct packed {
		logic load;
		logic emit;
	} bsbp_cmd_t;

	typedef struct packed {
		logic masked_nonzero;
		logic last;
		logic out_free;
	} bsbp_status_t;

endpackage

// ===== hdl/bsbp_ctrl.sv =====
// controller: idle / scan sequencing of one bitmap word at a time
module bsbp_ctrl
	import bsbp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  bsbp_status_t status,
	output bsbp_cmd_t    cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					if (status.masked_nonzero) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.emit = status.out_free;
				if (status.out_free && status.last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/bsbp_datapath.sv =====
// datapath: window registers, word mask, lowest-bit scan, slot counter, output register
module bsbp_datapath
	import bsbp_pkg::*;
#(
	parameter int POS_BITS  = 32,
	parameter int SLOT_BITS = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic [WORD_BITS-1:0]      mark_bits,
	input  logic [WIDX_BITS-1:0]      word_index,
	input  logic                      restart,
	input  bsbp_cmd_t                 cmd,
	output bsbp_status_t              status,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [FULL_POS_BITS-1:0]  position,
	output logic [SLOT_FIELD_BITS-1:0] slot,
	output logic                      last_of_word
);

	localparam int PB = (POS_BITS < FULL_POS_BITS) ? POS_BITS : FULL_POS_BITS;
	localparam logic [FULL_POS_BITS-1:0] POS_MASK =
		FULL_POS_BITS'((64'd1 << PB) - 64'd1);

	logic [FULL_POS_BITS-1:0]   win_start_q;
	logic [FULL_POS_BITS-1:0]   win_end_q;
	logic [SLOT_FIELD_BITS-1:0] base_slot_q;
	logic [SLOT_BITS-1:0]       slot_cnt_q;
	logic [WORD_BITS-1:0]       word_q;
	logic [WIDX_BITS-1:0]       widx_q;
	logic                       out_valid_q;
	logic [FULL_POS_BITS-1:0]   pos_q;
	logic [SLOT_FIELD_BITS-1:0] slot_q;
	logic                       last_q;

	logic [WIDX_BITS-1:0] start_hi;
	logic [WIDX_BITS-1:0] end_hi;
	logic [WORD_BITS-1:0] lo_mask;
	logic [WORD_BITS-1:0] hi_mask;
	logic [WORD_BITS-1:0] masked;
	logic [WORD_BITS-1:0] lsb;
	logic [WORD_BITS-1:0] word_rest;
	logic [IDX_BITS-1:0]  bit_idx;

	assign start_hi = win_start_q[FULL_POS_BITS-1:IDX_BITS];
	assign end_hi   = win_end_q[FULL_POS_BITS-1:IDX_BITS];

	// bits of the incoming word that fall inside the window
	always_comb begin
		if (start_hi < word_index) begin
			lo_mask = '1;
		end else if (start_hi == word_index) begin
			lo_mask = {WORD_BITS{1'b1}} << win_start_q[IDX_BITS-1:0];
		end else begin
			lo_mask = '0;
		end
		if (end_hi > word_index) begin
			hi_mask = '1;
		end else if (end_hi == word_index) begin
			hi_mask = {WORD_BITS{1'b1}} >> (6'd63 - win_end_q[IDX_BITS-1:0]);
		end else begin
			hi_mask = '0;
		end
		masked = mark_bits & lo_mask & hi_mask;
	end

	// isolate the lowest set bit and encode it
	always_comb begin
		lsb       = word_q & (~word_q + 64'd1);
		word_rest = word_q & ~lsb;
		bit_idx   = '0;
		for (int k = 0; k < WORD_BITS; k++) begin
			if (lsb[k]) begin
				bit_idx = bit_idx | IDX_BITS'(k);
			end
		end
	end

	assign status.masked_nonzero = (masked != '0);
	assign status.last           = (word_rest == '0);
	assign status.out_free       = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_start_q <= '0;
			win_end_q   <= '1;
			base_slot_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WINDOW_START: win_start_q <= cfg_data;
				REG_WINDOW_END:   win_end_q   <= cfg_data;
				REG_BASE_SLOT:    base_slot_q <= cfg_data[SLOT_FIELD_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_cnt_q <= '0;
		end else if (cmd.load && restart) begin
			slot_cnt_q <= SLOT_BITS'(base_slot_q);
		end else if (cmd.emit) begin
			slot_cnt_q <= slot_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			word_q <= masked;
			widx_q <= word_index;
		end else if (cmd.emit) begin
			word_q <= word_rest;
		end
		if (cmd.emit) begin
			pos_q  <= {widx_q, bit_idx} & POS_MASK;
			slot_q <= SLOT_FIELD_BITS'(slot_cnt_q);
			last_q <= (word_rest == '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign position     = pos_q;
	assign slot         = slot_q;
	assign last_of_word = last_q;

endmodule

// ===== hdl/bitmap_set_bit_positions.sv =====
// top level of the bitmap set-bit position flattener
//
// s_* channel: one 64-bit bitmap word with its word index per transfer;
//   s_tuser carries the restart flag, which reloads the slot counter from
//   base_slot before the word is scanned.
// m_* channel: one set-bit position inside the window per transfer, with
//   its slot number; m_tlast marks the final position of a word.
// cfg_* channel: register writes (0 window_start, 1 window_end,
//   2 base_slot), always ready; write only while the block is idle.
// timing: a word is taken while idle; the lowest set bit scan then sends one
//   position per cycle while the receiver keeps up, and a word with no
//   positions in the window leaves the block idle. the first position is
//   registered from the scan state once the output register is free.
// the output register holds a result while the receiver stalls;
//   a stalled receiver holds the scan, and s_tready is low during the scan.
// reset: window spans all positions, base_slot and slot counter are zero,
//   no result is pending.
module bitmap_set_bit_positions
	import bsbp_pkg::*;
#(
	parameter int POS_BITS  = 32,
	parameter int SLOT_BITS = 20
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [S_TDATA_BITS-1:0]   s_tdata,   // mark_bits, word_index, zero pad
	input  logic                      s_tuser,   // restart
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [M_TDATA_BITS-1:0]   m_tdata,   // position, slot, zero pad
	output logic                      m_tlast,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

	bsbp_cmd_t    cmd;
	bsbp_status_t status;

	logic [FULL_POS_BITS-1:0]   position;
	logic [SLOT_FIELD_BITS-1:0] slot;

	assign cfg_ready = 1'b1;

	bsbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	bsbp_datapath #(
		.POS_BITS  (POS_BITS),
		.SLOT_BITS (SLOT_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mark_bits    (s_tdata[WORD_BITS-1:0]),
		.word_index   (s_tdata[WORD_BITS+WIDX_BITS-1:WORD_BITS]),
		.restart      (s_tuser),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.position     (position),
		.slot         (slot),
		.last_of_word (m_tlast)
	);

	assign m_tdata = {{(M_TDATA_BITS-FULL_POS_BITS-SLOT_FIELD_BITS){1'b0}}, slot, position};

endmodule

// ===== hdl/bsbp_checker.sv =====
// port-level checks for the bitmap set-bit position block, bound to the top level
module bsbp_checker
	import bsbp_pkg::*;
(
	input logic                    clk,
	input logic                    arst_n,
	input logic                    s_tready,
	input logic                    m_tvalid,
	input logic                    m_tready,
	input logic [M_TDATA_BITS-1:0] m_tdata,
	input logic                    m_tlast
);

	// stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// new results only come out of a scan, never while input is open
	a_no_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
		else $error("result appeared while idle");

	// mid-word result means the scan is still running
	a_busy_mid_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input open before word finished");

	// scan keeps pace with the receiver inside a word
	a_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("gap inside a word");

endmodule

bind bitmap_set_bit_positions bsbp_checker u_bsbp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

// ===== test/tb_bitmap_set_bit_positions.sv =====
// testbench for the bitmap set-bit position flattener
module tb_bitmap_set_bit_positions;
	import bsbp_pkg::*;

	localparam int LIMIT_CYCLES    = 1_000_000;
	localparam int SETTLE_LIMIT    = 50_000;
	localparam int DRAIN_CYCLES    = 6;
	localparam int WORDS_PER_PHASE = 60;
	localparam int MAX_REPORTS     = 50;
	localparam int PAD_LO          = FULL_POS_BITS + SLOT_FIELD_BITS;

	localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
	typedef enum int {ROW_WORD, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic [FULL_POS_BITS-1:0]   pos;
		logic [SLOT_FIELD_BITS-1:0] slot;
		logic                       last;
	} position_t;

	typedef struct {
		row_kind_t                 kind;
		logic [CFG_INDEX_BITS-1:0] idx;
		logic [CFG_DATA_BITS-1:0]  value;
		logic [WORD_BITS-1:0]      mark;
		logic [WIDX_BITS-1:0]      widx;
		logic                      restart;
		bit                        typed;
		int                        n_typed;
		logic [FULL_POS_BITS-1:0]  t_pos;
		logic [SLOT_FIELD_BITS-1:0] t_slot;
	} row_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [S_TDATA_BITS-1:0]   s_tdata = '0;   // mark_bits, word_index, zero pad
	logic                      s_tuser = 1'b0; // restart
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [M_TDATA_BITS-1:0]   m_tdata;        // position, slot, zero pad
	logic                      m_tlast;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

	// predictor state
	logic [FULL_POS_BITS-1:0]   win_lo = '0;
	logic [FULL_POS_BITS-1:0]   win_hi = '1;
	logic [SLOT_FIELD_BITS-1:0] base_slot_r = '0;
	logic [SLOT_FIELD_BITS-1:0] next_slot = '0;

	position_t  positions_due[$];
	idle_mode_t idle_mode = IDLE_NONE;
	int         errors = 0;
	int         cycles = 0;

	bitmap_set_bit_positions dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (errors < MAX_REPORTS)
			$display("mismatch at cycle %0d: %s want %h got %h", cycles, what, want, got);
		errors++;
	endtask

	function automatic int stall_pct(input bit sender);
		case (idle_mode)
			IDLE_SENDER:   return sender ? 75 : 0;
			IDLE_RECEIVER: return sender ? 0 : 75;
			IDLE_BOTH:     return 10;
			default:       return 0;
		endcase
	endfunction

	function automatic row_t word_row(input logic [WORD_BITS-1:0] mark,
			input logic [WIDX_BITS-1:0] widx, input logic restart);
		row_t r;
		r = '{kind: ROW_WORD, idx: '0, value: '0, mark: mark, widx: widx,
			restart: restart, typed: 1'b0, n_typed: 0, t_pos: '0, t_slot: '0};
		return r;
	endfunction

	function automatic row_t typed_row(input logic [WORD_BITS-1:0] mark,
			input logic [WIDX_BITS-1:0] widx, input logic restart, input int n,
			input logic [FULL_POS_BITS-1:0] pos, input logic [SLOT_FIELD_BITS-1:0] slot);
		row_t r;
		r = word_row(mark, widx, restart);
		r.typed = 1'b1;
		r.n_typed = n;
		r.t_pos = pos;
		r.t_slot = slot;
		return r;
	endfunction

	function automatic row_t cfg_row(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] value);
		row_t r;
		r = word_row('0, '0, 1'b0);
		r.kind = ROW_CFG;
		r.idx = idx;
		r.value = value;
		return r;
	endfunction

	// scans one word lowest bit first; queues the positions unless told not to
	function automatic void flatten_word(input logic [WORD_BITS-1:0] mark,
			input logic [WIDX_BITS-1:0] widx, input logic restart, input bit keep);
		logic [FULL_POS_BITS-1:0] pos;
		position_t rec;
		int n;
		n = 0;
		if (restart)
			next_slot = base_slot_r;
		for (int k = 0; k < WORD_BITS; k++) begin
			pos = {widx, 6'(k)};
			if (mark[k] && pos >= win_lo && pos <= win_hi) begin
				rec.pos = pos;
				rec.slot = next_slot;
				rec.last = 1'b0;
				if (keep)
					positions_due.push_back(rec);
				next_slot = next_slot + 1'b1;
				n++;
			end
		end
		if (keep && n > 0)
			positions_due[positions_due.size()-1].last = 1'b1;
	endfunction

	task automatic send_word(input row_t r);
		position_t rec;
		while ($urandom_range(0, 99) < stall_pct(1'b1)) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_TDATA_BITS-WORD_BITS-WIDX_BITS){1'b0}}, r.widx, r.mark};
		s_tuser <= r.restart;
		do @(posedge clk); while (!s_tready);
		// queue after the edge so the result check never races the push
		@(negedge clk);
		flatten_word(r.mark, r.widx, r.restart, !r.typed);
		if (r.typed && r.n_typed > 0) begin
			rec.pos = r.t_pos;
			rec.slot = r.t_slot;
			rec.last = 1'b1;
			positions_due.push_back(rec);
		end
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_WINDOW_START: win_lo = value;
			REG_WINDOW_END:   win_hi = value;
			REG_BASE_SLOT:    base_slot_r = value[SLOT_FIELD_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// holds the input side off until every position is out and the scan has ended
	task automatic settle();
		int waited = 0;
		s_tvalid <= 1'b0;
		while (positions_due.size() != 0 && waited < SETTLE_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		if (positions_due.size() != 0) begin
			report_mismatch("positions never delivered", 64'(positions_due.size()), 64'd0);
			positions_due.delete();
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	always @(negedge clk)
		m_tready <= ($urandom_range(0, 99) >= stall_pct(1'b0));

	always @(posedge clk) begin : check_positions
		position_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (positions_due.size() == 0) begin
				report_mismatch("position with none expected", 64'd0, 64'(m_tdata));
			end else begin
				want = positions_due.pop_front();
				if (m_tdata[FULL_POS_BITS-1:0] !== want.pos)
					report_mismatch("position", 64'(want.pos),
						64'(m_tdata[FULL_POS_BITS-1:0]));
				if (m_tdata[FULL_POS_BITS +: SLOT_FIELD_BITS] !== want.slot)
					report_mismatch("slot", 64'(want.slot),
						64'(m_tdata[FULL_POS_BITS +: SLOT_FIELD_BITS]));
				if (m_tlast !== want.last)
					report_mismatch("last_of_word", 64'(want.last), 64'(m_tlast));
				if (m_tdata[M_TDATA_BITS-1:PAD_LO] !== '0)
					report_mismatch("tdata pad", 64'd0,
						64'(m_tdata[M_TDATA_BITS-1:PAD_LO]));
			end
		end
	end

	initial begin
		row_t                      directed_rows[$];
		idle_mode_t                phase_modes[4];
		logic [WIDX_BITS-1:0]      region;
		logic [WIDX_BITS-1:0]      widx;
		logic [WORD_BITS-1:0]      mark;
		logic [FULL_POS_BITS:0]    lo_ext;
		logic [FULL_POS_BITS:0]    hi_ext;
		logic [CFG_DATA_BITS-1:0]  lo;
		logic [CFG_DATA_BITS-1:0]  hi;
		logic [CFG_DATA_BITS-1:0]  base;
		bit                        full_window;

		phase_modes = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
		directed_rows = '{
			typed_row(64'h1, 26'd0, 1'b0, 1, 32'd0, 20'd0),
			typed_row(64'h0, 26'd5, 1'b0, 0, 32'd0, 20'd0),
			typed_row(64'h8000_0000_0000_0000, 26'h3FF_FFFF, 1'b0, 1, 32'hFFFF_FFFF, 20'd1),
			word_row('1, 26'd1, 1'b1),
			// base wider than the slot field, then a restart that wraps the counter
			cfg_row(REG_BASE_SLOT, 32'hFFFF_FFFF),
			word_row(64'h5, 26'd2, 1'b1),
			cfg_row(REG_WINDOW_START, 32'd130),
			cfg_row(REG_WINDOW_END, 32'd200),
			word_row('1, 26'd2, 1'b0),
			word_row('1, 26'd3, 1'b0),
			// nothing in the window, but the restart still reloads the counter
			typed_row('1, 26'd0, 1'b1, 0, 32'd0, 20'd0),
			typed_row(64'h4, 26'd2, 1'b0, 1, 32'd130, 20'hF_FFFF),
			cfg_row(REG_UNUSED, 32'd0),
			typed_row(64'h4, 26'd2, 1'b0, 1, 32'd130, 20'd0),
			// inverted window
			cfg_row(REG_WINDOW_START, 32'd300),
			cfg_row(REG_WINDOW_END, 32'd100),
			typed_row('1, 26'd4, 1'b1, 0, 32'd0, 20'd0),
			cfg_row(REG_WINDOW_START, 32'hFFFF_FFFF),
			cfg_row(REG_WINDOW_END, 32'hFFFF_FFFF),
			typed_row('1, 26'h3FF_FFFF, 1'b1, 1, 32'hFFFF_FFFF, 20'hF_FFFF),
			cfg_row(REG_BASE_SLOT, 32'd0),
			cfg_row(REG_WINDOW_START, 32'd0),
			cfg_row(REG_WINDOW_END, 32'd0),
			typed_row(64'h3, 26'd0, 1'b1, 1, 32'd0, 20'd0)
		};

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				settle();
				write_reg(directed_rows[i].idx, directed_rows[i].value);
			end else begin
				send_word(directed_rows[i]);
			end
		end

		for (int p = 0; p < 4; p++) begin
			settle();
			full_window = (p % 2 == 0);
			region = WIDX_BITS'($urandom);
			if (full_window) begin
				lo = '0;
				hi = '1;
			end else begin
				lo_ext = {1'b0, region, 6'd0} + 33'($urandom_range(0, 150));
				hi_ext = lo_ext + 33'($urandom_range(0, 500));
				lo = lo_ext[FULL_POS_BITS] ? '1 : lo_ext[FULL_POS_BITS-1:0];
				hi = hi_ext[FULL_POS_BITS] ? '1 : hi_ext[FULL_POS_BITS-1:0];
			end
			base = (p == 0) ? 32'h000F_FFF0 : $urandom;
			write_reg(REG_WINDOW_START, lo);
			write_reg(REG_WINDOW_END, hi);
			write_reg(REG_BASE_SLOT, base);
			idle_mode = phase_modes[p];
			repeat (WORDS_PER_PHASE) begin
				case ($urandom_range(0, 9))
					0: mark = '0;
					1: mark = '1;
					2, 3: mark = {$urandom, $urandom};
					default: begin
						// sparse word, like real structural marks
						mark = '0;
						repeat ($urandom_range(1, 4))
							mark[$urandom_range(0, WORD_BITS-1)] = 1'b1;
					end
				endcase
				if (full_window || $urandom_range(0, 7) == 0)
					widx = WIDX_BITS'($urandom);
				else
					widx = region + WIDX_BITS'($urandom_range(0, 11));
				send_word(word_row(mark, widx, $urandom_range(0, 7) == 0));
			end
		end

		settle();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
